/* design/rmsn_pkg.sv */
// ----------------------------------------------------------------------------
// rmsn_pkg
// shared types and constants of the rms normalization block
// ----------------------------------------------------------------------------
package rmsn_pkg;

  typedef struct packed {
    logic signed [15:0] sample;
    logic signed [15:0] gain;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] result;
    logic               clipped;
    logic               zero_norm;
    logic               final_res;
  } out_item_t;

  localparam int SumW = 37;
  localparam int RadW = 38;
  localparam int RootW = 19;
  localparam int ProdW = 32;
  localparam int QuoW = 32;

  localparam logic CfgLen = 1'b0;
  localparam logic CfgEps = 1'b1;

  // command from the front part to the back part
  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [6:0]      len;
    logic [31:0]     eps;
  } job_t;

endpackage

/* design/rmsn_front.sv */
// ----------------------------------------------------------------------------
// rmsn_front
// counts elements, accumulates squares and issues one job per vector
// ----------------------------------------------------------------------------
module rmsn_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rmsn_pkg::in_item_t in_item,
  input  logic [6:0]        len_eff,
  input  logic [31:0]       eps,
  input  logic              job_full,
  output logic              job_push,
  output rmsn_pkg::job_t    job,
  output logic              busy
);
  import rmsn_pkg::*;

  logic [SumW-1:0] square_sum;
  logic [6:0]      fill_count;
  logic [6:0]      fill_next;
  logic [31:0]     sq;
  logic            take;

  assign take = push && !busy;
  assign sq = 32'($signed(in_item.sample) * $signed(in_item.sample));
  assign fill_next = fill_count + 7'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum <= '0;
      fill_count <= '0;
      job_push <= 1'b0;
      busy <= 1'b0;
    end else begin
      if (job_push && !job_full) begin
        job_push <= 1'b0;
      end
      if (busy && !job_push) begin
        busy <= 1'b0;
      end
      if (take) begin
        if (fill_next >= len_eff) begin
          job_push <= 1'b1;
          busy <= 1'b1;
          job.sum <= square_sum + SumW'(sq);
          job.len <= len_eff;
          job.eps <= eps;
          square_sum <= '0;
          fill_count <= '0;
        end else begin
          square_sum <= square_sum + SumW'(sq);
          fill_count <= fill_next;
        end
      end
    end
  end
endmodule

/* design/rmsn_back.sv */
// ----------------------------------------------------------------------------
// rmsn_back
// mean, root and per element division in one iterative state machine
// ----------------------------------------------------------------------------
module rmsn_back #(
  parameter int MaxLen = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  rmsn_pkg::job_t     job,
  output logic               job_pop,
  output logic [$clog2(MaxLen > 1 ? MaxLen : 2)-1:0] rd_addr,
  input  logic signed [15:0] rd_sample,
  input  logic signed [15:0] rd_gain,
  output logic               res_valid,
  output rmsn_pkg::out_item_t res,
  input  logic               res_ready,
  output logic               busy
);
  import rmsn_pkg::*;

  localparam int AW = $clog2(MaxLen > 1 ? MaxLen : 2);
  localparam logic [2:0] S_IDLE = 3'd0, S_MEAN = 3'd1, S_ROOT = 3'd2, S_RD = 3'd3,
                         S_MUL = 3'd4, S_DIV = 3'd5, S_OUT = 3'd6;

  logic [2:0]       state;
  logic [SumW-1:0]  rem;
  logic [SumW-1:0]  quo;
  logic [5:0]       cnt;
  logic [6:0]       len;
  logic [31:0]      eps;
  logic [RadW-1:0]  rad;
  logic [RootW-1:0] root;
  logic [RadW:0]    rrem;
  logic [6:0]       k;
  logic             neg;
  logic [ProdW-1:0] pmag;
  logic [ProdW-1:0] dquo;
  logic [ProdW:0]   drem;
  logic [SumW:0]    mtrial;
  logic [RadW+1:0]  rtrial;
  logic [RadW+1:0]  rshift;
  logic [ProdW:0]   dshift;
  logic signed [31:0] prod;

  assign busy = state != S_IDLE;
  assign job_pop = state == S_IDLE && job_valid;
  assign rd_addr = k[AW-1:0];
  assign prod = 32'(rd_sample * rd_gain);
  assign mtrial = {rem, quo[SumW-1]} - {{(SumW-6){1'b0}}, len};
  assign rshift = {rrem[RadW-1:0], rad[RadW-1 -: 2]};
  assign rtrial = rshift - {{(RadW-RootW){1'b0}}, root, 2'b01};
  assign dshift = {drem[ProdW-1:0], pmag[ProdW-1]};
  assign res_valid = state == S_OUT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            quo <= job.sum;
            rem <= '0;
            len <= job.len;
            eps <= job.eps;
            cnt <= 6'(SumW - 1);
            state <= S_MEAN;
          end
        end
        S_MEAN: begin
          quo <= {quo[SumW-2:0], !mtrial[SumW]};
          rem <= mtrial[SumW] ? {rem[SumW-2:0], quo[SumW-1]} : mtrial[SumW-1:0];
          if (cnt == 0) begin
            cnt <= 6'(RootW - 1);
            rrem <= '0;
            root <= '0;
            state <= S_ROOT;
          end else begin
            cnt <= cnt - 6'd1;
          end
          if (cnt == 0) begin
            rad <= RadW'({quo[SumW-2:0], !mtrial[SumW]}) + RadW'(eps);
          end
        end
        S_ROOT: begin
          rad <= {rad[RadW-3:0], 2'b00};
          if (rtrial[RadW+1]) begin
            rrem <= rshift[RadW:0];
            root <= {root[RootW-2:0], 1'b0};
          end else begin
            rrem <= rtrial[RadW:0];
            root <= {root[RootW-2:0], 1'b1};
          end
          if (cnt == 0) begin
            k <= '0;
            state <= S_RD;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        S_RD: state <= S_MUL;
        S_MUL: begin
          neg <= prod[31];
          pmag <= prod[31] ? 32'(-prod) : 32'(prod);
          dquo <= '0;
          drem <= '0;
          cnt <= 6'(ProdW - 1);
          state <= (root == 0) ? S_OUT : S_DIV;
          res.zero_norm <= root == 0;
          res.clipped <= 1'b0;
          res.result <= '0;
          res.final_res <= k + 7'd1 == len;
        end
        S_DIV: begin
          pmag <= {pmag[ProdW-2:0], 1'b0};
          if (dshift >= {{(ProdW+1-RootW){1'b0}}, root}) begin
            drem <= dshift - {{(ProdW+1-RootW){1'b0}}, root};
            dquo <= {dquo[ProdW-2:0], 1'b1};
          end else begin
            drem <= dshift;
            dquo <= {dquo[ProdW-2:0], 1'b0};
          end
          if (cnt == 0) begin
            state <= S_OUT;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        S_OUT: begin
          if (res_ready) begin
            if (res.final_res) begin
              state <= S_IDLE;
            end else begin
              k <= k + 7'd1;
              state <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_DIV && cnt == 0) begin
        if (!neg && {dquo[ProdW-2:0], dshift >= {{(ProdW+1-RootW){1'b0}}, root}} > 32'd32767)
        begin
          res.result <= 16'sh7fff;
          res.clipped <= 1'b1;
        end else if (neg && {dquo[ProdW-2:0], dshift >= {{(ProdW+1-RootW){1'b0}}, root}} >
                     32'd32768) begin
          res.result <= -16'sh8000;
          res.clipped <= 1'b1;
        end else if (neg) begin
          res.result <= 16'(-{dquo[ProdW-2:0], dshift >= {{(ProdW+1-RootW){1'b0}}, root}});
        end else begin
          res.result <= 16'({dquo[ProdW-2:0], dshift >= {{(ProdW+1-RootW){1'b0}}, root}});
        end
      end
    end
  end
endmodule

/* design/rms_normalize_vector.sv */
// ----------------------------------------------------------------------------
// rms_normalize_vector
// rms normalization of a vector of weighted fixed point elements
// ----------------------------------------------------------------------------
// channel  direction  handshake     payload
// in       input      push / full   sample, gain
// out      output     empty / pop   result, clipped, zero_norm, final_res
// cfg      input      cfg_we        vector_length (0), epsilon (1)
//
// one element per cycle while a vector fills; after the last element the
// serial state machine computes the mean, then the root, then per result a
// read, a multiply and a division unless the root is zero, plus output handshake.
// reset is synchronous; stores hold no reset value.
// full stays high while a completed vector is being processed.
module rms_normalize_vector #(
  parameter int MAX_LEN = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rmsn_pkg::in_item_t  in_item,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output rmsn_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);
  import rmsn_pkg::*;

  localparam int AW = $clog2(MAX_LEN > 1 ? MAX_LEN : 2);

  logic [6:0]  vector_length;
  logic [31:0] epsilon;
  logic [6:0]  len_eff;
  logic [6:0]  fill;
  logic        front_busy, back_busy, job_push, job_pop, res_valid;
  job_t        job;
  logic [AW-1:0] rd_addr;
  logic signed [15:0] sample_store [MAX_LEN];
  logic signed [15:0] gain_store [MAX_LEN];
  logic signed [15:0] rd_sample, rd_gain;

  assign len_eff = (vector_length == 7'd0) ? 7'd1 :
                   (vector_length > 7'(MAX_LEN)) ? 7'(MAX_LEN) : vector_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= 7'd64;
      epsilon <= 32'd17;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgLen: vector_length <= cfg_data[6:0];
        CfgEps: epsilon <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (push && !full) begin
      fill <= (7'(fill + 7'd1) >= len_eff) ? 7'd0 : 7'(fill + 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      sample_store[fill[AW-1:0]] <= in_item.sample;
      gain_store[fill[AW-1:0]] <= in_item.gain;
    end
    rd_sample <= sample_store[rd_addr];
    rd_gain <= gain_store[rd_addr];
  end

  assign full = front_busy || back_busy;
  assign empty = !res_valid;

  rmsn_front u_front (
    .clk, .rst, .push(push && !back_busy), .in_item,
    .len_eff, .eps(epsilon), .job_full(1'b0), .job_push, .job, .busy(front_busy)
  );

  rmsn_back #(.MaxLen(MAX_LEN)) u_back (
    .clk, .rst, .job_valid(job_push), .job, .job_pop, .rd_addr,
    .rd_sample, .rd_gain, .res_valid, .res(out_item), .res_ready(pop),
    .busy(back_busy)
  );

`ifndef ASSERT_OFF
  a_no_push_busy: assert property (@(posedge clk) disable iff (rst)
    back_busy |-> full) else $error("input taken during processing");
  a_job_taken: assert property (@(posedge clk) disable iff (rst)
    job_push |-> job_pop) else $error("job not taken");
`endif
endmodule
